// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the stepper controller blocks
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising edge out of reset
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: hw/rtl/shpc_pkg.sv
// ----------------------------------------------------------------------------
// shpc_pkg
// types, codes and reset values shared by the stepper homing controller
// ----------------------------------------------------------------------------
package shpc_pkg;

    // command opcodes as they arrive on the input stream
    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_MOVE_TO = 3'd1;
    localparam logic [2:0] OP_MOVE_BY = 3'd2;
    localparam logic [2:0] OP_HOME    = 3'd3;
    localparam logic [2:0] OP_STOP    = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_STEP_LOW   = 3'd0;
    localparam logic [2:0] CFG_PULSE_HIGH = 3'd1;
    localparam logic [2:0] CFG_SETTLE     = 3'd2;
    localparam logic [2:0] CFG_DEBOUNCE   = 3'd3;
    localparam logic [2:0] CFG_HOME_PAUSE = 3'd4;
    localparam logic [2:0] CFG_BACKOFF    = 3'd5;
    localparam logic [2:0] CFG_ACTIVE_LVL = 3'd6;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // configuration reset values
    localparam logic [15:0] RST_STEP_LOW   = 16'd3000;
    localparam logic [7:0]  RST_PULSE_HIGH = 8'd5;
    localparam logic [7:0]  RST_SETTLE     = 8'd10;
    localparam logic [7:0]  RST_DEBOUNCE   = 8'd50;
    localparam logic [19:0] RST_HOME_PAUSE = 20'd500000;
    localparam logic [15:0] RST_BACKOFF    = 16'd100;
    localparam logic        RST_ACTIVE_LVL = 1'b1;

    // result event codes
    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_DONE    = 2'd1;
    localparam logic [1:0] EV_LIMITED = 2'd2;
    localparam logic [1:0] EV_HOMED   = 2'd3;

    // command queue depth between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // stream widths
    localparam int IN_DATA_W  = 40;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 40;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_MOVE_TO,
        CMD_MOVE_BY,
        CMD_HOME,
        CMD_STOP
    } t_cmd;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SETTLE,
        PH_DEBOUNCE,
        PH_HIGH,
        PH_LOW,
        PH_PAUSE,
        PH_BACK_HIGH,
        PH_BACK_LOW
    } t_phase;

    // one classified tick as held in the queue
    typedef struct packed {
        t_cmd        kind;
        logic [31:0] value;
        logic        lvl_active;   // switch reads pressed this tick
        logic        lim_edge;     // switch went into pressed this tick
    } t_entry;

    // valid-qualified entry between modules
    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_q_word;

    // configuration bundle
    typedef struct packed {
        logic [15:0] step_low;
        logic [7:0]  pulse_high;
        logic [7:0]  settle;
        logic [7:0]  debounce;
        logic [19:0] home_pause;
        logic [15:0] backoff;
        logic        active_lvl;
    } t_cfg;

endpackage

// File: hw/rtl/shpc_front.sv
// ----------------------------------------------------------------------------
// shpc_front
// accepts input words, decodes the opcode and detects the limit switch edge
// ----------------------------------------------------------------------------
module shpc_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_active_lvl,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [31:0] command_value, [32] limit_level, [39:33] zero
    input  logic [shpc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // [2:0] opcode
    input  logic [shpc_pkg::IN_USER_W-1:0]    s_axis_tuser,
    input  logic                              i_q_full,
    output shpc_pkg::t_q_word                 o_push
);
    import shpc_pkg::*;

    logic r_prev_limit;
    logic w_level;
    logic w_accept;
    t_cmd w_kind;

    assign w_level       = s_axis_tdata[32];
    assign s_axis_tready = !i_q_full;
    assign w_accept      = s_axis_tvalid && !i_q_full;

    // opcode decode, unused codes are plain ticks
    always_comb begin
        unique case (s_axis_tuser)
            OP_MOVE_TO: w_kind = CMD_MOVE_TO;
            OP_MOVE_BY: w_kind = CMD_MOVE_BY;
            OP_HOME:    w_kind = CMD_HOME;
            OP_STOP:    w_kind = CMD_STOP;
            default:    w_kind = CMD_NONE;
        endcase
    end

    // classified word toward the queue
    always_comb begin
        o_push.valid            = w_accept;
        o_push.entry.kind       = w_kind;
        o_push.entry.value      = s_axis_tdata[31:0];
        o_push.entry.lvl_active = (w_level == i_active_lvl);
        o_push.entry.lim_edge   = (w_level == i_active_lvl) && (r_prev_limit != i_active_lvl);
    end

    // previous raw switch level, advanced per accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_limit <= 1'b0;
        end else if (w_accept) begin
            r_prev_limit <= w_level;
        end
    end

endmodule

// File: hw/rtl/shpc_queue.sv
// ----------------------------------------------------------------------------
// shpc_queue
// small fifo of classified ticks between the front and the back
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module shpc_queue #(
    parameter int DEPTH = shpc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  shpc_pkg::t_q_word  i_push,
    input  logic               i_pop,
    output logic               o_full,
    output shpc_pkg::t_q_word  o_head
);
    import shpc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_entry           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full        = (r_count == CNT_FULL);
    assign w_push        = i_push.valid && !o_full;
    assign w_pop         = i_pop && (r_count != '0);
    assign o_head.valid  = (r_count != '0);
    assign o_head.entry  = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push.entry;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `ASSERT_IMPLY(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_FULL)
    `ASSERT_NEXT(a_pop_drains, i_clk, i_rst_n, w_pop && !w_push, r_count == $past(r_count) - 1'b1)
    `ASSERT_NEXT(a_push_fills, i_clk, i_rst_n, w_push && !w_pop, r_count == $past(r_count) + 1'b1)

endmodule

// File: hw/rtl/shpc_back.sv
// ----------------------------------------------------------------------------
// shpc_back
// motion sequencer: runs one queued tick per cycle while the output is not stalled and registers the result
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module shpc_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  shpc_pkg::t_cfg                   i_cfg,
    input  shpc_pkg::t_q_word                i_head,
    output logic                             o_pop,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [0] step_out, [1] dir_out, [2] enable_out, [34:3] position,
    // [35] busy_res, [37:36] event_res, [39:38] zero
    output logic [shpc_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import shpc_pkg::*;

    // sequencer state
    t_phase      r_phase, n_phase;
    logic [19:0] r_wait, n_wait;
    logic [31:0] r_steps, n_steps;
    logic [31:0] r_pos, n_pos;
    logic        r_up, n_up;
    logic        r_homing, n_homing;
    logic        r_latch, n_latch;
    logic        r_dir, n_dir;
    logic        r_en, n_en;
    logic        r_step, n_step;
    logic [1:0]  n_event;

    // result register
    logic        r_ov;
    logic        r_o_step, r_o_dir, r_o_en, r_o_busy;
    logic [31:0] r_o_pos;
    logic [1:0]  r_o_event;

    t_entry      w_e;
    logic        w_wait_done;
    logic [19:0] w_wait_dec;
    logic [31:0] w_base;
    logic [31:0] w_diff;
    logic [31:0] w_ndiff;
    logic        w_do_check;
    logic        w_chk_zero;
    logic        w_do_limit;
    logic        w_do_pulse;
    t_phase      w_pulse_ph;
    logic        w_do_back;
    logic        w_back_zero;

    assign w_e         = i_head.entry;
    assign o_pop       = i_head.valid && (!r_ov || m_axis_tready);
    assign w_wait_done = (r_wait <= 20'd1);
    assign w_wait_dec  = r_wait - 20'd1;

    // move distance for both move commands
    assign w_base  = (w_e.kind == CMD_MOVE_TO) ? r_pos : 32'd0;
    assign w_diff  = w_e.value - w_base;
    assign w_ndiff = w_base - w_e.value;

    // next state for one tick
    always_comb begin
        n_phase    = r_phase;
        n_wait     = r_wait;
        n_steps    = r_steps;
        n_pos      = r_pos;
        n_up       = r_up;
        n_homing   = r_homing;
        n_latch    = r_latch | w_e.lim_edge;
        n_dir      = r_dir;
        n_en       = r_en;
        n_step     = r_step;
        n_event    = EV_NONE;
        w_do_check = 1'b0;
        w_chk_zero = 1'b0;
        w_do_limit = 1'b0;
        w_do_pulse = 1'b0;
        w_pulse_ph = PH_HIGH;
        w_do_back  = 1'b0;
        w_back_zero = 1'b0;

        unique case (r_phase) inside
            PH_IDLE: begin
                unique case (w_e.kind) inside
                    CMD_MOVE_TO, CMD_MOVE_BY: begin
                        if (w_diff == 32'd0) begin
                            n_event = EV_DONE;
                        end else begin
                            n_up     = !w_diff[31];
                            n_steps  = w_diff[31] ? w_ndiff : w_diff;
                            n_dir    = !w_diff[31];
                            n_en     = 1'b1;
                            n_homing = 1'b0;
                            n_phase  = PH_SETTLE;
                            n_wait   = {12'd0, i_cfg.settle};
                        end
                    end
                    CMD_HOME: begin
                        n_latch  = 1'b0;
                        n_homing = 1'b1;
                        n_up     = 1'b0;
                        n_dir    = 1'b0;
                        n_en     = 1'b1;
                        n_phase  = PH_SETTLE;
                        n_wait   = {12'd0, i_cfg.settle};
                    end
                    CMD_STOP: begin
                        n_step = 1'b0;
                        n_en   = 1'b0;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
            PH_SETTLE: begin
                n_wait = w_wait_done ? 20'd0 : w_wait_dec;
                if (w_wait_done) begin
                    w_do_check = 1'b1;
                    w_chk_zero = (r_steps == 32'd0);
                end
            end
            PH_DEBOUNCE: begin
                n_wait = w_wait_done ? 20'd0 : w_wait_dec;
                if (w_wait_done) begin
                    w_do_limit = w_e.lvl_active;
                    w_do_pulse = !w_e.lvl_active;
                end
            end
            PH_HIGH, PH_BACK_HIGH: begin
                n_wait = w_wait_done ? 20'd0 : w_wait_dec;
                if (w_wait_done) begin
                    n_step  = 1'b0;
                    n_phase = (r_phase == PH_HIGH) ? PH_LOW : PH_BACK_LOW;
                    n_wait  = {4'd0, i_cfg.step_low};
                end
            end
            PH_LOW: begin
                n_wait = w_wait_done ? 20'd0 : w_wait_dec;
                if (w_wait_done) begin
                    if (!r_homing) begin
                        n_pos   = r_up ? r_pos + 32'd1 : r_pos - 32'd1;
                        n_steps = r_steps - 32'd1;
                    end
                    w_do_check = 1'b1;
                    w_chk_zero = (r_steps == 32'd1);
                end
            end
            PH_PAUSE: begin
                n_wait = w_wait_done ? 20'd0 : w_wait_dec;
                if (w_wait_done) begin
                    n_dir       = 1'b1;
                    n_steps     = {16'd0, i_cfg.backoff};
                    w_do_back   = 1'b1;
                    w_back_zero = (i_cfg.backoff == 16'd0);
                end
            end
            PH_BACK_LOW: begin
                n_wait = w_wait_done ? 20'd0 : w_wait_dec;
                if (w_wait_done) begin
                    n_steps     = r_steps - 32'd1;
                    w_do_back   = 1'b1;
                    w_back_zero = (r_steps == 32'd1);
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        // check before a step: done, latched limit, pressed switch or pulse
        if (w_do_check) begin
            if (!r_homing && w_chk_zero) begin
                n_phase = PH_IDLE;
                n_event = EV_DONE;
            end else if (n_latch) begin
                w_do_limit = 1'b1;
            end else if (w_e.lvl_active) begin
                n_phase = PH_DEBOUNCE;
                n_wait  = {12'd0, i_cfg.debounce};
            end else begin
                w_do_pulse = 1'b1;
            end
        end

        // back-off step or finish homing
        if (w_do_back) begin
            if (w_back_zero) begin
                n_pos    = {16'd0, i_cfg.backoff};
                n_latch  = 1'b0;
                n_homing = 1'b0;
                n_phase  = PH_IDLE;
                n_event  = EV_HOMED;
            end else begin
                w_do_pulse = 1'b1;
                w_pulse_ph = PH_BACK_HIGH;
            end
        end

        // limit reached: homing pauses, a move aborts
        if (w_do_limit) begin
            n_step = 1'b0;
            if (r_homing) begin
                n_pos   = 32'd0;
                n_phase = PH_PAUSE;
                n_wait  = i_cfg.home_pause;
            end else begin
                n_en    = 1'b0;
                n_latch = 1'b0;
                n_phase = PH_IDLE;
                n_event = EV_LIMITED;
            end
        end

        // start a step pulse
        if (w_do_pulse) begin
            n_step  = 1'b1;
            n_phase = w_pulse_ph;
            n_wait  = {12'd0, i_cfg.pulse_high};
        end
    end

    // phase register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else if (o_pop) begin
            r_phase <= n_phase;
        end
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait   <= '0;
            r_steps  <= '0;
            r_pos    <= '0;
            r_up     <= 1'b0;
            r_homing <= 1'b0;
            r_latch  <= 1'b0;
            r_dir    <= 1'b0;
            r_en     <= 1'b0;
            r_step   <= 1'b0;
        end else if (o_pop) begin
            r_wait   <= n_wait;
            r_steps  <= n_steps;
            r_pos    <= n_pos;
            r_up     <= n_up;
            r_homing <= n_homing;
            r_latch  <= n_latch;
            r_dir    <= n_dir;
            r_en     <= n_en;
            r_step   <= n_step;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (o_pop) begin
            r_ov <= 1'b1;
        end else if (m_axis_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_o_step  <= n_step;
            r_o_dir   <= n_dir;
            r_o_en    <= n_en;
            r_o_pos   <= n_pos;
            r_o_busy  <= (n_phase != PH_IDLE);
            r_o_event <= n_event;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {2'b00, r_o_event, r_o_busy, r_o_pos, r_o_en, r_o_dir, r_o_step};

    `ASSERT_IMPLY(a_step_needs_enable, i_clk, i_rst_n, r_step, r_en)
    `ASSERT_IMPLY(a_event_ends_run, i_clk, i_rst_n, o_pop && (n_event != EV_NONE),
                  n_phase == PH_IDLE)
    `ASSERT_NEXT(a_stall_holds_word, i_clk, i_rst_n, r_ov && !m_axis_tready,
                 r_ov && $stable(r_o_pos) && $stable(r_o_event))

endmodule

// File: hw/rtl/stepper_homing_position_controller.sv
// ----------------------------------------------------------------------------
// stepper_homing_position_controller
// Step, direction and enable generator with absolute/relative moves, homing
// against a limit switch and a wrapping 32-bit step position. Each input word
// is one timing tick (opcode in tuser, command value and raw switch level in
// tdata) and yields exactly one output word with the pin levels, position,
// busy flag and event code of that tick. One word is taken and one produced
// per clock when neither side stalls; the front decodes and edge-detects the
// switch in the accept cycle, a four-word queue sits before the motion
// sequencer, and the sequencer registers its result. Configuration registers
// are written through the plain write port and must only change while no
// words are in flight.
// ----------------------------------------------------------------------------
module stepper_homing_position_controller #(
    parameter int QUEUE_DEPTH = shpc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [shpc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [shpc_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    // tick input
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [31:0] command_value, [32] limit_level, [39:33] zero
    input  logic [shpc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [2:0] opcode
    input  logic [shpc_pkg::IN_USER_W-1:0]     s_axis_tuser,
    // result output
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [0] step_out, [1] dir_out, [2] enable_out, [34:3] position,
    // [35] busy_res, [37:36] event_res, [39:38] zero
    output logic [shpc_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import shpc_pkg::*;

    t_cfg    r_cfg;
    t_q_word w_push;
    t_q_word w_head;
    logic    w_full;
    logic    w_pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_low   <= RST_STEP_LOW;
            r_cfg.pulse_high <= RST_PULSE_HIGH;
            r_cfg.settle     <= RST_SETTLE;
            r_cfg.debounce   <= RST_DEBOUNCE;
            r_cfg.home_pause <= RST_HOME_PAUSE;
            r_cfg.backoff    <= RST_BACKOFF;
            r_cfg.active_lvl <= RST_ACTIVE_LVL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_STEP_LOW:   r_cfg.step_low   <= i_cfg_wdata[15:0];
                CFG_PULSE_HIGH: r_cfg.pulse_high <= i_cfg_wdata[7:0];
                CFG_SETTLE:     r_cfg.settle     <= i_cfg_wdata[7:0];
                CFG_DEBOUNCE:   r_cfg.debounce   <= i_cfg_wdata[7:0];
                CFG_HOME_PAUSE: r_cfg.home_pause <= i_cfg_wdata[19:0];
                CFG_BACKOFF:    r_cfg.backoff    <= i_cfg_wdata[15:0];
                CFG_ACTIVE_LVL: r_cfg.active_lvl <= i_cfg_wdata[0];
                default:        r_cfg            <= r_cfg;
            endcase
        end
    end

    // decode and switch edge detect
    shpc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_active_lvl  (r_cfg.active_lvl),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_q_full      (w_full),
        .o_push        (w_push)
    );

    // decoupling queue
    shpc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_head  (w_head)
    );

    // motion sequencer
    shpc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// File: verif/shpc_checker.sv
// ----------------------------------------------------------------------------
// shpc_checker
// Watches the tick and result streams of the stepper homing controller,
// mirrors the configuration writes, predicts the pin levels, position, busy
// flag and event code of every accepted tick and compares each result word
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shpc_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [shpc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [shpc_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic                                 i_s_tvalid,
    input  logic                                 i_s_tready,
    // [31:0] command_value, [32] limit_level, [39:33] zero
    input  logic [shpc_pkg::IN_DATA_W-1:0]       i_s_tdata,
    // [2:0] opcode
    input  logic [shpc_pkg::IN_USER_W-1:0]       i_s_tuser,
    input  logic                                 i_m_tvalid,
    input  logic                                 i_m_tready,
    // [0] step_out, [1] dir_out, [2] enable_out, [34:3] position,
    // [35] busy_res, [37:36] event_res, [39:38] zero
    input  logic [shpc_pkg::OUT_DATA_W-1:0]      i_m_tdata,
    output int                                   o_fail_count,
    output int                                   o_pending,
    output logic                                 o_motion_idle
);
    import shpc_pkg::*;

    // one predicted result word
    typedef struct packed {
        logic        step;
        logic        dir;
        logic        enable;
        logic [31:0] position;
        logic        busy;
        logic [1:0]  evt;
    } tick_result_t;

    // predicted results still waiting for their word
    tick_result_t pin_state_q[$];
    int           fail_total;

    // mirrored configuration
    t_cfg         cfg_q;

    // motion sequencer state
    t_phase       seq_phase;
    logic [19:0]  tick_wait;
    logic [31:0]  steps_to_go;
    logic [31:0]  step_pos;
    logic         heading_up;
    logic         homing;
    logic         lim_latch;
    logic         last_level;
    logic         dir_pin;
    logic         enable_pin;
    logic         step_pin;
    logic [1:0]   event_code;

    function void reset_motion();
        cfg_q       = '{RST_STEP_LOW, RST_PULSE_HIGH, RST_SETTLE, RST_DEBOUNCE,
                        RST_HOME_PAUSE, RST_BACKOFF, RST_ACTIVE_LVL};
        seq_phase   = PH_IDLE;
        tick_wait   = '0;
        steps_to_go = '0;
        step_pos    = '0;
        heading_up  = 1'b0;
        homing      = 1'b0;
        lim_latch   = 1'b0;
        last_level  = 1'b0;
        dir_pin     = 1'b0;
        enable_pin  = 1'b0;
        step_pin    = 1'b0;
        event_code  = EV_NONE;
    endfunction

    function void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_STEP_LOW:   cfg_q.step_low   = data[15:0];
            CFG_PULSE_HIGH: cfg_q.pulse_high = data[7:0];
            CFG_SETTLE:     cfg_q.settle     = data[7:0];
            CFG_DEBOUNCE:   cfg_q.debounce   = data[7:0];
            CFG_HOME_PAUSE: cfg_q.home_pause = data[19:0];
            CFG_BACKOFF:    cfg_q.backoff    = data[15:0];
            CFG_ACTIVE_LVL: cfg_q.active_lvl = data[0];
            default: ;
        endcase
    endfunction

    // a wait of zero or one tick expires on its first tick
    function logic count_down();
        if (tick_wait <= 20'd1) begin
            tick_wait = '0;
            return 1'b1;
        end
        tick_wait = tick_wait - 20'd1;
        return 1'b0;
    endfunction

    function void raise_step(t_phase high_phase);
        step_pin  = 1'b1;
        seq_phase = high_phase;
        tick_wait = 20'(cfg_q.pulse_high);
    endfunction

    // switch found: homing pauses, a move aborts with the driver off
    function void switch_hit();
        step_pin = 1'b0;
        if (homing) begin
            step_pos  = '0;
            seq_phase = PH_PAUSE;
            tick_wait = cfg_q.home_pause;
        end else begin
            enable_pin = 1'b0;
            lim_latch  = 1'b0;
            seq_phase  = PH_IDLE;
            event_code = EV_LIMITED;
        end
    endfunction

    // checks done before every step of a move or of the seek
    function void check_step(logic lvl);
        if (!homing && steps_to_go == 32'd0) begin
            seq_phase  = PH_IDLE;
            event_code = EV_DONE;
        end else if (lim_latch) begin
            switch_hit();
        end else if (lvl == cfg_q.active_lvl) begin
            seq_phase = PH_DEBOUNCE;
            tick_wait = 20'(cfg_q.debounce);
        end else begin
            raise_step(PH_HIGH);
        end
    endfunction

    function void next_backoff();
        if (steps_to_go == 32'd0) begin
            step_pos   = 32'(cfg_q.backoff);
            lim_latch  = 1'b0;
            homing     = 1'b0;
            seq_phase  = PH_IDLE;
            event_code = EV_HOMED;
        end else begin
            raise_step(PH_BACK_HIGH);
        end
    endfunction

    function void begin_move(logic [31:0] distance);
        if (distance == 32'd0) begin
            event_code = EV_DONE;
            return;
        end
        heading_up  = ~distance[31];
        steps_to_go = heading_up ? distance : (32'd0 - distance);
        dir_pin     = heading_up;
        enable_pin  = 1'b1;
        homing      = 1'b0;
        seq_phase   = PH_SETTLE;
        tick_wait   = 20'(cfg_q.settle);
    endfunction

    // advance the sequencer by one tick and return the pins it shows
    function tick_result_t advance_motion(logic [2:0] op, logic [31:0] val, logic lvl);
        tick_result_t res;
        event_code = EV_NONE;
        if (lvl == cfg_q.active_lvl && last_level != cfg_q.active_lvl)
            lim_latch = 1'b1;
        last_level = lvl;

        case (seq_phase)
            PH_IDLE: begin
                case (op)
                    OP_MOVE_TO: begin_move(val - step_pos);
                    OP_MOVE_BY: begin_move(val);
                    OP_HOME: begin
                        lim_latch  = 1'b0;
                        homing     = 1'b1;
                        heading_up = 1'b0;
                        dir_pin    = 1'b0;
                        enable_pin = 1'b1;
                        seq_phase  = PH_SETTLE;
                        tick_wait  = 20'(cfg_q.settle);
                    end
                    OP_STOP: begin
                        step_pin   = 1'b0;
                        enable_pin = 1'b0;
                    end
                    default: ;
                endcase
            end
            PH_SETTLE: begin
                if (count_down())
                    check_step(lvl);
            end
            PH_DEBOUNCE: begin
                if (count_down()) begin
                    if (lvl == cfg_q.active_lvl)
                        switch_hit();
                    else
                        raise_step(PH_HIGH);
                end
            end
            PH_HIGH: begin
                if (count_down()) begin
                    step_pin  = 1'b0;
                    seq_phase = PH_LOW;
                    tick_wait = 20'(cfg_q.step_low);
                end
            end
            PH_LOW: begin
                if (count_down()) begin
                    if (!homing) begin
                        step_pos    = step_pos + (heading_up ? 32'd1 : 32'hFFFF_FFFF);
                        steps_to_go = steps_to_go - 32'd1;
                    end
                    check_step(lvl);
                end
            end
            PH_PAUSE: begin
                if (count_down()) begin
                    dir_pin     = 1'b1;
                    steps_to_go = 32'(cfg_q.backoff);
                    next_backoff();
                end
            end
            PH_BACK_HIGH: begin
                if (count_down()) begin
                    step_pin  = 1'b0;
                    seq_phase = PH_BACK_LOW;
                    tick_wait = 20'(cfg_q.step_low);
                end
            end
            PH_BACK_LOW: begin
                if (count_down()) begin
                    steps_to_go = steps_to_go - 32'd1;
                    next_backoff();
                end
            end
            default: seq_phase = PH_IDLE;
        endcase

        res.step     = step_pin;
        res.dir      = dir_pin;
        res.enable   = enable_pin;
        res.position = step_pos;
        res.busy     = (seq_phase != PH_IDLE);
        res.evt      = event_code;
        return res;
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_total++;
        end
    endfunction

    // predict on every accepted tick, compare on every accepted result
    always @(posedge i_clk) begin
        tick_result_t want;
        tick_result_t got;
        if (!i_rst_n) begin
            reset_motion();
            pin_state_q.delete();
            fail_total = 0;
        end else begin
            if (i_cfg_we)
                apply_cfg(i_cfg_index, i_cfg_wdata);
            if (i_s_tvalid && i_s_tready)
                pin_state_q.push_back(advance_motion(i_s_tuser, i_s_tdata[31:0],
                                                     i_s_tdata[32]));
            if (i_m_tvalid && i_m_tready) begin
                got.step     = i_m_tdata[0];
                got.dir      = i_m_tdata[1];
                got.enable   = i_m_tdata[2];
                got.position = i_m_tdata[34:3];
                got.busy     = i_m_tdata[35];
                got.evt      = i_m_tdata[37:36];
                if (pin_state_q.size() == 0) begin
                    $error("result word arrived with no tick waiting for it");
                    fail_total++;
                end else begin
                    want = pin_state_q.pop_front();
                    check_field("step_out", 32'(want.step), 32'(got.step));
                    check_field("dir_out", 32'(want.dir), 32'(got.dir));
                    check_field("enable_out", 32'(want.enable), 32'(got.enable));
                    check_field("position", want.position, got.position);
                    check_field("busy_res", 32'(want.busy), 32'(got.busy));
                    check_field("event_res", 32'(want.evt), 32'(got.evt));
                end
            end
        end
        o_fail_count  <= fail_total;
        o_pending     <= pin_state_q.size();
        o_motion_idle <= (seq_phase == PH_IDLE);
    end

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives tick words into the stepper homing controller with bursty timing and
// a switch level made of long and bouncing runs, lets the result side stall on
// its own pattern, and steps through several register settings with the
// sequencer brought back to idle between them. The checker beside the block
// predicts and compares; this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import shpc_pkg::*;

    // opcodes the block has no use for
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    localparam int STALL_LIMIT  = 4000;
    localparam int RANDOM_TICKS = 250;
    localparam int HOLD_CYCLES  = 150;
    localparam int NUM_PLANS    = 7;

    typedef enum int {RX_OPEN, RX_BUSY, RX_SPARSE} rx_mode_t;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_wdata;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    // [31:0] command_value, [32] limit_level, [39:33] zero
    logic [IN_DATA_W-1:0]    s_axis_tdata;
    // [2:0] opcode
    logic [IN_USER_W-1:0]    s_axis_tuser;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    // [0] step_out, [1] dir_out, [2] enable_out, [34:3] position,
    // [35] busy_res, [37:36] event_res, [39:38] zero
    logic [OUT_DATA_W-1:0]   m_axis_tdata;

    int   fail_count;
    int   pending;
    logic motion_idle;

    // sender and switch state
    int   burst_left;
    int   level_run;
    logic switch_level;
    bit   sending_random;
    t_cfg plan [NUM_PLANS];

    stepper_homing_position_controller i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_wdata   (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    shpc_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_wdata   (cfg_wdata),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_s_tuser     (s_axis_tuser),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_motion_idle (motion_idle)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // switch level: long presses and releases mixed with short bounces
    function logic next_level();
        if (level_run == 0) begin
            switch_level = ~switch_level;
            level_run = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3)
                                                    : $urandom_range(5, 250);
        end
        level_run--;
        return switch_level;
    endfunction

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
    endtask

    task automatic program_regs(input t_cfg c);
        put_reg(CFG_STEP_LOW, 20'(c.step_low));
        put_reg(CFG_PULSE_HIGH, 20'(c.pulse_high));
        put_reg(CFG_SETTLE, 20'(c.settle));
        put_reg(CFG_DEBOUNCE, 20'(c.debounce));
        put_reg(CFG_HOME_PAUSE, c.home_pause);
        put_reg(CFG_BACKOFF, 20'(c.backoff));
        put_reg(CFG_ACTIVE_LVL, 20'(c.active_lvl));
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // offer one tick word, in bursts separated by random gaps
    task automatic send_word(input logic [2:0] op, input logic [31:0] val, input logic lvl);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 40);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, lvl, val};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        burst_left--;
    endtask

    // mostly plain ticks, with short moves, homing, stops and spare opcodes mixed in
    task automatic run_random(input int count);
        int          pick;
        logic [2:0]  op;
        logic [31:0] val;
        sending_random = 1'b1;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            val  = $urandom;
            if (pick < 84) begin
                op = OP_TICK;
            end else if (pick < 89) begin
                op = OP_MOVE_BY;
                if ($urandom_range(0, 9) != 0)
                    val = 32'($urandom_range(0, 4)) - 32'd2;
            end else if (pick < 93) begin
                op = OP_MOVE_TO;
                if ($urandom_range(0, 9) != 0)
                    val = 32'($urandom_range(0, 6)) - 32'd3;
            end else if (pick < 96) begin
                op = OP_HOME;
            end else if (pick < 98) begin
                op = OP_STOP;
            end else begin
                op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
            end
            send_word(op, val, next_level());
        end
        sending_random = 1'b0;
    endtask

    // keep ticking until the sequencer is idle, then let every result drain
    task automatic settle_idle();
        do send_word(OP_TICK, $urandom, next_level()); while (!motion_idle);
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // result side: stretches of open, busy and sparse ready, one long hold
    initial begin
        rx_mode_t mode;
        int       span;
        int       cycles;
        bit       hold_done;
        m_axis_tready = 1'b0;
        cycles    = 0;
        hold_done = 1'b0;
        forever begin
            mode = rx_mode_t'($urandom_range(0, 2));
            span = $urandom_range(20, 200);
            repeat (span) begin
                @(posedge i_clk);
                cycles++;
                case (mode)
                    RX_OPEN: m_axis_tready <= 1'b1;
                    RX_BUSY: m_axis_tready <= ($urandom_range(0, 3) != 0);
                    default: m_axis_tready <= ($urandom_range(0, 9) < 3);
                endcase
            end
            if (!hold_done && sending_random && cycles > 600) begin
                hold_done = 1'b1;
                @(posedge i_clk);
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_wdata      = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = '0;
        burst_left     = 0;
        level_run      = 0;
        switch_level   = 1'b1;
        sending_random = 1'b0;

        // step_low, pulse_high, settle, debounce, home_pause, backoff, active
        plan[0] = '{16'd200, 8'd1, 8'd1, 8'd0, 20'd0, 16'd0, 1'b1};
        plan[1] = '{16'd200, 8'd3, 8'd4, 8'd5, 20'd30, 16'd2, 1'b0};
        plan[2] = '{16'd250, 8'd255, 8'd255, 8'd255, 20'd100, 16'd1, 1'b1};
        plan[3] = '{16'($urandom_range(200, 400)), 8'($urandom_range(1, 20)),
                    8'($urandom_range(1, 20)), 8'($urandom_range(0, 30)),
                    20'($urandom_range(0, 200)), 16'($urandom_range(0, 3)),
                    1'($urandom_range(0, 1))};
        plan[4] = '{16'($urandom_range(200, 400)), 8'($urandom_range(1, 20)),
                    8'($urandom_range(1, 20)), 8'($urandom_range(0, 30)),
                    20'($urandom_range(0, 200)), 16'($urandom_range(0, 3)),
                    1'($urandom_range(0, 1))};
        plan[5] = '{16'd200, 8'd1, 8'd1, 8'd0, 20'd0, 16'd3, 1'b0};
        // every register at its top value; the run ends inside these waits
        plan[6] = '{16'd65535, 8'd255, 8'd255, 8'd255, 20'hFFFFF, 16'd65535, 1'b1};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        program_regs(plan[0]);

        // value extremes, stop while idle, spare opcodes, zero-length moves
        send_word(OP_TICK, 32'd0, 1'b0);
        send_word(OP_TICK, 32'hFFFF_FFFF, 1'b0);
        send_word(OP_STOP, 32'h7FFF_FFFF, 1'b0);
        send_word(OP_SPARE_LO, 32'h8000_0000, 1'b0);
        send_word(OP_SPARE_HI, $urandom, 1'b0);
        send_word(OP_MOVE_TO, 32'd0, 1'b0);
        send_word(OP_MOVE_BY, 32'd0, 1'b0);
        // press while idle leaves a stale latch that kills the next move
        send_word(OP_TICK, 32'd0, 1'b1);
        send_word(OP_TICK, 32'd0, 1'b0);
        send_word(OP_MOVE_BY, 32'd1, 1'b0);
        send_word(OP_HOME, 32'd0, 1'b0);
        send_word(OP_TICK, 32'd0, 1'b0);
        // longest move down, with commands arriving while it runs
        send_word(OP_MOVE_BY, 32'h8000_0000, 1'b0);
        send_word(OP_STOP, 32'd0, 1'b0);
        send_word(OP_MOVE_TO, 32'h7FFF_FFFF, 1'b1);
        send_word(OP_HOME, 32'hFFFF_FFFF, 1'b1);
        send_word(OP_MOVE_BY, 32'h7FFF_FFFF, 1'b0);

        run_random(RANDOM_TICKS);
        settle_idle();

        for (int p = 1; p < NUM_PLANS - 1; p++) begin
            program_regs(plan[p]);
            run_random(RANDOM_TICKS);
            settle_idle();
        end

        program_regs(plan[NUM_PLANS - 1]);
        run_random(RANDOM_TICKS);
        s_axis_tvalid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (10) @(posedge i_clk);

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/shpc_pkg.sv
hw/rtl/shpc_front.sv
hw/rtl/shpc_queue.sv
hw/rtl/shpc_back.sv
hw/rtl/stepper_homing_position_controller.sv
verif/shpc_checker.sv
verif/tb.sv
